// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned MAG_W    = 32;
    localparam int unsigned RAD_W    = 66;
    localparam int unsigned ROOT_W   = 33;
    localparam int unsigned SQ_REM_W = 35;
    localparam int unsigned STR_W    = 34;
    localparam int unsigned M_W      = 48;
    localparam int unsigned U_W      = 31;
    localparam int unsigned DV_REM_W = 34;
    localparam int unsigned C_W      = 49;
    localparam int unsigned F_W      = 50;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned NUM_AXES  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 8'd1;

    localparam logic signed [F_W-1:0] SAT_MAX = 50'sh0_7FFF_FFFF;
    localparam logic signed [F_W-1:0] SAT_MIN = -50'sh0_8000_0000;

    // Data that rides along the square root chain.
    typedef struct packed {
        logic [NUM_AXES-1:0][MAG_W-1:0] mag;
        logic [NUM_AXES-1:0]            dneg;
    } t_sq_side;

    // Data that rides along the division chain.
    typedef struct packed {
        logic [ROOT_W-1:0]        len;
        logic [M_W-1:0]           m;
        logic signed [STR_W-1:0]  s;
        logic [NUM_AXES-1:0]      dneg;
    } t_dv_side;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_force_x;
        logic signed [COORD_W-1:0] first_force_y;
        logic signed [COORD_W-1:0] first_force_z;
        logic signed [COORD_W-1:0] second_force_x;
        logic signed [COORD_W-1:0] second_force_y;
        logic signed [COORD_W-1:0] second_force_z;
        logic signed [COORD_W-1:0] stretch;
    } t_result;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [F_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/sfd_if.sv =====
interface sfd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  output ready);
endinterface

interface sfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_force_x;
    logic signed [31:0] first_force_y;
    logic signed [31:0] first_force_z;
    logic signed [31:0] second_force_x;
    logic signed [31:0] second_force_y;
    logic signed [31:0] second_force_z;
    logic signed [31:0] stretch;
    modport source (output valid, first_force_x, first_force_y, first_force_z,
                    second_force_x, second_force_y, second_force_z, stretch,
                    input ready);
    modport sink (input valid, first_force_x, first_force_y, first_force_z,
                  second_force_x, second_force_y, second_force_z, stretch,
                  output ready);
endinterface

interface sfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sfd_sqrt_cell.sv =====
module sfd_sqrt_cell import sfd_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    input  t_sq_side            i_side,
    output logic                o_valid,
    output logic [RAD_W-1:0]    o_rad,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [ROOT_W-1:0]   o_root,
    output t_sq_side            o_side
);

    logic [SQ_REM_W+1:0] w_shift;
    logic [SQ_REM_W+1:0] w_trial;
    logic                w_ge;
    logic [SQ_REM_W+1:0] w_diff;
    logic [SQ_REM_W-1:0] n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic                r_valid;
    logic [RAD_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    t_sq_side            r_side;

    // One restoring step: bring down the next bit pair and try root*4+1.
    always_comb begin
        w_shift = {i_rem, i_rad[2*IDX+1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_shift >= w_trial);
        w_diff  = w_shift - w_trial;
        n_rem   = w_ge ? w_diff[SQ_REM_W-1:0] : w_shift[SQ_REM_W-1:0];
        n_root  = {i_root[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// ===== rtl/sfd_div_cell.sv =====
module sfd_div_cell import sfd_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [NUM_AXES-1:0][DV_REM_W-1:0]  i_rem,
    input  logic [NUM_AXES-1:0][U_W-1:0]       i_quot,
    input  t_dv_side                           i_side,
    output logic                               o_valid,
    output logic [NUM_AXES-1:0][DV_REM_W-1:0]  o_rem,
    output logic [NUM_AXES-1:0][U_W-1:0]       o_quot,
    output t_dv_side                           o_side
);

    localparam bit FIRST = (IDX == U_W - 1);

    logic [DV_REM_W:0]                  w_t;
    logic [DV_REM_W:0]                  w_d;
    logic [NUM_AXES-1:0][DV_REM_W-1:0]  n_rem;
    logic [NUM_AXES-1:0][U_W-1:0]       n_quot;
    logic                               r_valid;
    logic [NUM_AXES-1:0][DV_REM_W-1:0]  r_rem;
    logic [NUM_AXES-1:0][U_W-1:0]       r_quot;
    t_dv_side                           r_side;

    // The first cell sees the plain magnitude, which never exceeds the length.
    always_comb begin
        w_t    = '0;
        w_d    = '0;
        n_rem  = i_rem;
        n_quot = i_quot;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_t = FIRST ? {1'b0, i_rem[a]} : {i_rem[a], 1'b0};
            w_d = w_t - {2'b00, i_side.len};
            if (w_t >= {2'b00, i_side.len}) begin
                n_rem[a]       = w_d[DV_REM_W-1:0];
                n_quot[a][IDX] = 1'b1;
            end else begin
                n_rem[a]       = w_t[DV_REM_W-1:0];
                n_quot[a][IDX] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule

// ===== rtl/spring_force_3d_unit.sv =====
// A request passes r0 to r2, the square root chain, r3 to r5, the divider chain,
// r6 to r8 and the output register. Throughput: one request per cycle while the
// skid entry is empty; the 33-cell square root and 31-cell divider chains each
// retire one bit per cell. A two-entry output stage lets one request in while
// a result waits. Reset (synchronous, active low) empties the pipeline and
// clears both configuration registers to zero.
module spring_force_3d_unit import sfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_cfg_if.sink   i_cfg,
    sfd_out_if.source o_out
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = U_W;

    logic w_en;

    logic [31:0] r_stiffness;
    logic [31:0] r_rest_length;

    // Front stages.
    logic                                  r0_v;
    t_sq_side                              r0;
    logic                                  r1_v;
    logic [NUM_AXES-1:0][2*MAG_W-1:0]      r1_sq;
    t_sq_side                              r1;
    logic                                  r2_v;
    logic [RAD_W-1:0]                      r2_rad;
    t_sq_side                              r2;

    logic signed [COORD_W-1:0] w_first  [NUM_AXES];
    logic signed [COORD_W-1:0] w_second [NUM_AXES];
    t_sq_side                  n0;
    logic signed [MAG_W:0]     w_d;

    logic                sq_v    [0:SQ_N];
    logic [RAD_W-1:0]    sq_rad  [0:SQ_N];
    logic [SQ_REM_W-1:0] sq_rem  [0:SQ_N];
    logic [ROOT_W-1:0]   sq_root [0:SQ_N];
    t_sq_side            sq_side [0:SQ_N];

    logic                    r3_v;
    logic [ROOT_W-1:0]       r3_len;
    logic signed [STR_W-1:0] r3_s;
    logic [ROOT_W-1:0]       r3_abs;
    t_sq_side                r3;
    logic signed [STR_W-1:0] w_s;

    logic                    r4_v;
    logic [47:0]             r4_pp_lo;
    logic [48:0]             r4_pp_hi;
    logic [ROOT_W-1:0]       r4_len;
    logic signed [STR_W-1:0] r4_s;
    t_sq_side                r4;

    logic [64:0] w_msum;

    logic                              dv_v    [0:DV_N];
    logic [NUM_AXES-1:0][DV_REM_W-1:0] dv_rem  [0:DV_N];
    logic [NUM_AXES-1:0][U_W-1:0]      dv_quot [0:DV_N];
    t_dv_side                          dv_side [0:DV_N];

    logic                          r5_v;
    t_dv_side                      r5;
    logic [NUM_AXES-1:0][MAG_W-1:0] r5_mag;

    logic                                   r6_v;
    logic [NUM_AXES-1:0][2:0][U_W+15:0]     r6_p;
    t_dv_side                               r6;

    logic                            r7_v;
    logic [NUM_AXES-1:0][C_W-1:0]    r7_c;
    t_dv_side                        r7;

    logic    r8_v;
    t_result r8;
    t_result n8;
    logic signed [F_W-1:0] w_f [NUM_AXES];
    logic signed [COORD_W-1:0] w_sec [NUM_AXES];
    logic signed [COORD_W-1:0] w_fst [NUM_AXES];

    logic    r_out_v;
    t_result r_out;
    logic    r_skid_v;
    t_result r_skid;

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    // Configuration.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness   <= '0;
            r_rest_length <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STIFFNESS:   r_stiffness   <= i_cfg.data;
                CFG_REST_LENGTH: r_rest_length <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage 0: per-axis difference, magnitude and sign.
    always_comb begin
        w_first[0]  = i_in.first_x;
        w_first[1]  = i_in.first_y;
        w_first[2]  = i_in.first_z;
        w_second[0] = i_in.second_x;
        w_second[1] = i_in.second_y;
        w_second[2] = i_in.second_z;
        n0  = '0;
        w_d = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_d = {w_first[a][COORD_W-1], w_first[a]} - {w_second[a][COORD_W-1], w_second[a]};
            n0.dneg[a] = w_d[MAG_W];
            n0.mag[a]  = w_d[MAG_W] ? 32'(-w_d) : w_d[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_in.valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0 <= n0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r1_sq[a] <= r0.mag[a] * r0.mag[a];
            end
            r1     <= r0;
            r2_rad <= {2'b00, r1_sq[0]} + {2'b00, r1_sq[1]} + {2'b00, r1_sq[2]};
            r2     <= r1;
        end
    end

    // Square root chain, most significant bit pair first.
    assign sq_v[0]    = r2_v;
    assign sq_rad[0]  = r2_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r2;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        sfd_sqrt_cell #(.IDX(SQ_N - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_v[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // Stages 3 to 5: stretch, then the stiffness product in two partial products.
    assign w_s    = {1'b0, sq_root[SQ_N]} - {2'b00, r_rest_length};
    assign w_msum = {r4_pp_hi, 16'b0} + {17'b0, r4_pp_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= sq_v[SQ_N];
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_len   <= sq_root[SQ_N];
            r3_s     <= w_s;
            r3_abs   <= w_s[STR_W-1] ? ROOT_W'(-w_s) : w_s[ROOT_W-1:0];
            r3       <= sq_side[SQ_N];
            r4_pp_lo <= r_stiffness * r3_abs[15:0];
            r4_pp_hi <= r_stiffness * r3_abs[32:16];
            r4_len   <= r3_len;
            r4_s     <= r3_s;
            r4       <= r3;
            r5.len   <= r4_len;
            r5.m     <= w_msum[64:17];
            r5.s     <= r4_s;
            r5.dneg  <= r4.dneg;
            r5_mag   <= r4.mag;
        end
    end

    // Unit vector division chain, one quotient bit per cell for all three axes.
    assign dv_v[0]    = r5_v;
    assign dv_side[0] = r5;
    assign dv_quot[0] = '0;
    assign dv_rem[0]  = {{2'b00, r5_mag[2]}, {2'b00, r5_mag[1]}, {2'b00, r5_mag[0]}};

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        sfd_div_cell #(.IDX(DV_N - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_v[k]),
            .i_rem   (dv_rem[k]),
            .i_quot  (dv_quot[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_v[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quot  (dv_quot[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // Stages 6 to 8: unit times magnitude, then sign and saturation.
    always_comb begin
        n8 = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r7.len == '0) begin
                w_f[a] = '0;
            end else if (r7.dneg[a] != r7.s[STR_W-1]) begin
                w_f[a] = -$signed({1'b0, r7_c[a]});
            end else begin
                w_f[a] = $signed({1'b0, r7_c[a]});
            end
            w_sec[a] = sat32(w_f[a]);
            w_fst[a] = sat32(-w_f[a]);
        end
        n8.second_force_x = w_sec[0];
        n8.second_force_y = w_sec[1];
        n8.second_force_z = w_sec[2];
        n8.first_force_x  = w_fst[0];
        n8.first_force_y  = w_fst[1];
        n8.first_force_z  = w_fst[2];
        n8.stretch        = sat32(F_W'(r7.s));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= dv_v[DV_N];
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r6_p[a][0] <= dv_quot[DV_N][a] * dv_side[DV_N].m[15:0];
                r6_p[a][1] <= dv_quot[DV_N][a] * dv_side[DV_N].m[31:16];
                r6_p[a][2] <= dv_quot[DV_N][a] * dv_side[DV_N].m[47:32];
                r7_c[a]    <= 49'(({r6_p[a][2], 32'b0} + {16'b0, r6_p[a][1], 16'b0}
                                   + {32'b0, r6_p[a][0]}) >> 30);
            end
            r6 <= dv_side[DV_N];
            r7 <= r6;
            r8 <= n8;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out_v <= r8_v;
        end else if (r8_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out <= r8;
        end else begin
            r_skid <= r8;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.first_force_x  = r_out.first_force_x;
    assign o_out.first_force_y  = r_out.first_force_y;
    assign o_out.first_force_z  = r_out.first_force_z;
    assign o_out.second_force_x = r_out.second_force_x;
    assign o_out.second_force_y = r_out.second_force_y;
    assign o_out.second_force_z = r_out.second_force_z;
    assign o_out.stretch        = r_out.stretch;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_in.ready)
        else $error("input accepted while the skid entry is full");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r8_v && w_en && r_out_v && !o_out.ready) |=> r_skid_v)
        else $error("result dropped while the output was stalled");

    a_force_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.first_force_x == -o_out.second_force_x
            || (o_out.second_force_x == 32'sh7FFF_FFFF
                && o_out.first_force_x == 32'sh8000_0000)
            || (o_out.second_force_x == 32'sh8000_0000
                && o_out.first_force_x == 32'sh7FFF_FFFF)))
        else $error("forces on the two points are not opposite");

endmodule

// ===== tb/sv/spring_force_3d_unit_tb.sv =====
`timescale 1ns / 1ps

module spring_force_3d_unit_tb;
    import sfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd200;
    localparam int DRAIN_CYCLES = 90;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } t_spring_ends;

    logic i_clk;
    logic i_rst_n;

    sfd_in_if  in_if();
    sfd_cfg_if cfg_if();
    sfd_out_if out_if();

    spring_force_3d_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    logic [31:0] stiffness_q;
    logic [31:0] rest_length_q;
    t_result     force_queue[$];
    int          n_errors;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [127:0] root_floor(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -128'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Forces and stretch for one spring under the current register values.
    function automatic t_result spring_response(input t_spring_ends p);
        logic signed [127:0] a [3];
        logic signed [127:0] b [3];
        logic signed [127:0] d [3];
        logic [127:0]        mag [3];
        logic [127:0]        sum_sq;
        logic [127:0]        len;
        logic signed [127:0] s;
        logic [127:0]        abs_s;
        logic [127:0]        m;
        logic [127:0]        u;
        logic [127:0]        c;
        logic signed [127:0] f [3];
        t_result             r;
        a[0] = p.first_x;  a[1] = p.first_y;  a[2] = p.first_z;
        b[0] = p.second_x; b[1] = p.second_y; b[2] = p.second_z;
        sum_sq = '0;
        for (int k = 0; k < 3; k++) begin
            d[k] = a[k] - b[k];
            mag[k] = (d[k] < 0) ? -d[k] : d[k];
            sum_sq = sum_sq + mag[k] * mag[k];
        end
        len = root_floor(sum_sq);
        s = $signed(len) - $signed({96'd0, rest_length_q});
        abs_s = (s < 0) ? -s : s;
        m = ({96'd0, stiffness_q} * abs_s) >> 17;
        for (int k = 0; k < 3; k++) begin
            f[k] = 0;
            if (len != 0) begin
                u = (mag[k] << 30) / len;
                c = (u * m) >> 30;
                f[k] = ((d[k] < 0) != (s < 0)) ? -$signed(c) : $signed(c);
            end
        end
        r.second_force_x = clamp32(f[0]);
        r.second_force_y = clamp32(f[1]);
        r.second_force_z = clamp32(f[2]);
        r.first_force_x  = clamp32(-f[0]);
        r.first_force_y  = clamp32(-f[1]);
        r.first_force_z  = clamp32(-f[2]);
        r.stretch        = clamp32(s);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (force_queue.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                t_result e;
                e = force_queue.pop_front();
                check_field("first_force_x", e.first_force_x, out_if.first_force_x);
                check_field("first_force_y", e.first_force_y, out_if.first_force_y);
                check_field("first_force_z", e.first_force_z, out_if.first_force_z);
                check_field("second_force_x", e.second_force_x, out_if.second_force_x);
                check_field("second_force_y", e.second_force_y, out_if.second_force_y);
                check_field("second_force_z", e.second_force_z, out_if.second_force_z);
                check_field("stretch", e.stretch, out_if.stretch);
            end
        end
    end

    // The receiver decides its ready for the next edge at each falling edge.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // All driving tasks start and end just after a falling edge.
    task automatic send_spring(input t_spring_ends p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    = 1'b1;
        in_if.first_x  = p.first_x;
        in_if.first_y  = p.first_y;
        in_if.first_z  = p.first_z;
        in_if.second_x = p.second_x;
        in_if.second_y = p.second_y;
        in_if.second_z = p.second_z;
        do @(posedge i_clk); while (!in_if.ready);
        force_queue.push_back(spring_response(p));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (force_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_STIFFNESS) begin
            stiffness_q = value;
        end else if (idx == CFG_REST_LENGTH) begin
            rest_length_q = value;
        end
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_spring_ends make_spring(input logic signed [31:0] fx,
            input logic signed [31:0] fy, input logic signed [31:0] fz,
            input logic signed [31:0] sx, input logic signed [31:0] sy,
            input logic signed [31:0] sz);
        t_spring_ends p;
        p.first_x = fx;  p.first_y = fy;  p.first_z = fz;
        p.second_x = sx; p.second_y = sy; p.second_z = sz;
        return p;
    endfunction

    function automatic t_spring_ends random_spring();
        t_spring_ends p;
        logic signed [31:0] base [3];
        int kind;
        kind = $urandom_range(0, 9);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind >= 4 && kind <= 7) begin
            // Nearby points, so that forces mostly stay in range.
            for (int k = 0; k < 3; k++) begin
                base[k] = $urandom;
            end
            p.first_x  = base[0] + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
            p.first_y  = base[1] + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
            p.first_z  = base[2] + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
            p.second_x = base[0];
            p.second_y = base[1];
            p.second_z = base[2];
        end else if (kind == 8) begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
            p.second_z = p.first_z;
        end else if (kind == 9) begin
            p.first_y  = p.second_y;
            p.first_z  = p.second_z;
        end
        return p;
    endfunction

    task automatic test_register_writes();
        write_reg(CFG_STIFFNESS, 32'h0001_0000);
        write_reg(CFG_REST_LENGTH, 32'h0002_0000);
        // A write to an unknown index must leave both registers alone.
        write_reg(CFG_UNUSED_INDEX, 32'hDEAD_BEEF);
        send_spring(make_spring(32'sh0005_0000, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0));
    endtask

    task automatic test_directed();
        write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(CFG_REST_LENGTH, 32'h0000_0000);
        send_spring(make_spring(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_spring(make_spring(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_spring(make_spring(1, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 0, -1, 0, 0, 0));
        write_reg(CFG_REST_LENGTH, 32'hFFFF_FFFF);
        // Coincident points: no force, and the stretch saturates to the most negative value.
        send_spring(make_spring(32'sh1234_5678, -32'sh10, 32'sh7FFF_FFFF,
                                32'sh1234_5678, -32'sh10, 32'sh7FFF_FFFF));
        send_spring(make_spring(0, 0, 0, 0, 0, 0));
        send_spring(make_spring(32'sh0001_0000, 0, 0, 0, 0, 0));
        send_spring(make_spring(32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                                32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        write_reg(CFG_STIFFNESS, 32'h0000_8000);
        write_reg(CFG_REST_LENGTH, 32'h0001_0000);
        send_spring(make_spring(32'sh0000_8000, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 32'sh0003_0000, 0, 0, 0, 0));
        send_spring(make_spring(-32'sh0002_0000, 32'sh0002_0000, -32'sh0001_0000, 0, 0, 0));
        send_spring(make_spring(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        write_reg(CFG_STIFFNESS, 32'h0000_0000);
        send_spring(make_spring(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0));
        send_spring(make_spring(5, 7, 9, 0, 0, 0));
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_STIFFNESS, $urandom);
                    1: write_reg(CFG_STIFFNESS, $urandom_range(0, 32'h0010_0000));
                    2: write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
                    default: write_reg(CFG_STIFFNESS, $urandom_range(0, 32'h0001_0000));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_REST_LENGTH, $urandom);
                    1: write_reg(CFG_REST_LENGTH, 32'h0000_0000);
                    2: write_reg(CFG_REST_LENGTH, 32'hFFFF_FFFF);
                    default: write_reg(CFG_REST_LENGTH, $urandom_range(0, 32'h0020_0000));
                endcase
            end
            send_spring(random_spring());
        end
    endtask

    initial begin
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stiffness_q    = '0;
        rest_length_q  = '0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.first_x  = '0;
        in_if.first_y  = '0;
        in_if.first_z  = '0;
        in_if.second_x = '0;
        in_if.second_y = '0;
        in_if.second_z = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        out_if.ready   = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = 6;
        recv_stall_pct = 54;
        test_register_writes();
        test_directed();
        test_random(270);

        send_idle_pct  = 54;
        recv_stall_pct = 6;
        test_random(270);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(260);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
